[rtl/bulm_pkg.sv]
// Shared constants and types for the banked unaligned load/store memory.
package bulm_pkg;

    localparam int ADDR_WIDTH_DEF = 8;
    localparam int BANK_DEPTH_DEF = 64;
    localparam int OP_WIDTH       = 3;
    localparam int DATA_WIDTH     = 32;
    localparam int NUM_BANKS      = 4;
    localparam int LANE_WIDTH     = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD_BYTE  = 3'd0,
        OP_LOAD_HALF  = 3'd1,
        OP_LOAD_WORD  = 3'd2,
        OP_STORE_BYTE = 3'd3,
        OP_STORE_HALF = 3'd4,
        OP_STORE_WORD = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        SIZE_BYTE,
        SIZE_HALF,
        SIZE_WORD
    } size_t;

    // Access control carried between the address stages and the bank stage
    typedef struct packed {
        logic                  store;
        size_t                 size;
        logic [LANE_WIDTH-1:0] lane;
    } acc_ctrl_t;

endpackage

[rtl/bulm_if.sv]
// Request and response channel interfaces of the banked memory.
interface bulm_req_if #(
    parameter int ADDR_WIDTH = bulm_pkg::ADDR_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [bulm_pkg::OP_WIDTH-1:0]   op;
    logic [ADDR_WIDTH-1:0]           addr;
    logic [bulm_pkg::DATA_WIDTH-1:0] wdata;

    modport source (output valid, output op, output addr, output wdata, input ready);
    modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface bulm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bulm_pkg::DATA_WIDTH-1:0] rdata;

    modport source (output valid, output rdata, input ready);
    modport sink   (input valid, input rdata, output ready);
endinterface

[rtl/banked_unaligned_load_store_memory.sv]
// Top level of the four-bank byte-lane memory with unaligned big-endian access.
//
// Byte-addressed memory of four byte-wide banks: byte address a sits in bank
// a mod 4 at row (a div 4) mod BANK_DEPTH. Each request is a byte, halfword or
// word load or store at any address; every bank is touched at most once, so an
// unaligned access moves in a single bank cycle and bytes past the top address
// wrap to address 0. The lowest address holds the most significant byte; loads
// return zero-extended data on rsp, stores and undefined op codes return nothing.
// The block takes one request per cycle while nothing stalls it. On the way to rsp
// a load is registered in order: the reciprocal multiply with the request, then
// the multiply-subtract that finishes the row reduction, then the bank read.
// A load result held on rsp stalls the bank stage and, behind it, the request
// side; stores never wait on rsp.
// Contents are undefined until written; there is no clearing pass.
module banked_unaligned_load_store_memory #(
    parameter int ADDR_WIDTH = bulm_pkg::ADDR_WIDTH_DEF,
    parameter int BANK_DEPTH = bulm_pkg::BANK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bulm_req_if.sink    req,
    bulm_rsp_if.source  rsp
);

    localparam int RW = $clog2(BANK_DEPTH);
    localparam int NB = bulm_pkg::NUM_BANKS;
    localparam int LW = bulm_pkg::LANE_WIDTH;

    logic                            acc_valid;
    bulm_pkg::acc_ctrl_t             acc_ctrl;
    logic [bulm_pkg::DATA_WIDTH-1:0] acc_wdata;
    logic [RW-1:0]                   row_lo;
    logic [RW-1:0]                   row_hi;
    logic                            take;
    logic [LW-1:0]                   acc_last;

    logic [LW-1:0]                   bank_idx  [NB];
    logic [RW-1:0]                   bank_row  [NB];
    logic                            bank_we   [NB];
    logic [7:0]                      bank_wbyte[NB];
    logic [NB-1:0][7:0]              bank_q;
    logic                            bank_re;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    bulm_pkg::size_t                 rsp_size_reg;
    logic [LW-1:0]                   rsp_lane_reg;
    logic [NB-1:0][7:0]              load_bytes;
    logic [bulm_pkg::DATA_WIDTH-1:0] load_word;

    bulm_addr_gen #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .BANK_DEPTH (BANK_DEPTH)
    ) u_addr_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .take   (take),
        .valid  (acc_valid),
        .ctrl   (acc_ctrl),
        .wdata  (acc_wdata),
        .row_lo (row_lo),
        .row_hi (row_hi)
    );

    // Stores retire at the banks; loads need room in the response register
    assign take    = acc_valid && (acc_ctrl.store || !rsp_valid_reg || rsp.ready);
    assign bank_re = take && !acc_ctrl.store;

    always_comb
    begin
        unique case (acc_ctrl.size)
            bulm_pkg::SIZE_BYTE: acc_last = LW'(0);
            bulm_pkg::SIZE_HALF: acc_last = LW'(1);
            default:             acc_last = LW'(3);
        endcase
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_bank
        // Byte position within the access that lands on this bank
        assign bank_idx[k]   = LW'(k) - acc_ctrl.lane;
        assign bank_row[k]   = (LW'(k) >= acc_ctrl.lane) ? row_lo : row_hi;
        assign bank_we[k]    = take && acc_ctrl.store && (bank_idx[k] <= acc_last);
        assign bank_wbyte[k] = 8'(acc_wdata >> {acc_last - bank_idx[k], 3'b000});

        bulm_bank #(
            .BANK_DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[k]),
            .re    (bank_re),
            .addr  (bank_row[k]),
            .wdata (bank_wbyte[k]),
            .rdata (bank_q[k])
        );
    end

    always_comb
    begin
        if (bank_re)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_re)
        begin
            rsp_size_reg <= acc_ctrl.size;
            rsp_lane_reg <= acc_ctrl.lane;
        end
    end

    // Rotate bank lanes back into address order, first byte most significant
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            load_bytes[NB-1-i] = bank_q[LW'(rsp_lane_reg + LW'(i))];
        end
        unique case (rsp_size_reg)
            bulm_pkg::SIZE_BYTE: load_word = {24'd0, load_bytes[3]};
            bulm_pkg::SIZE_HALF: load_word = {16'd0, load_bytes[3], load_bytes[2]};
            default:             load_word = load_bytes;
        endcase
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.rdata = load_word;

endmodule

[rtl/bulm_addr_gen.sv]
// Request decode and two-stage row reduction modulo the bank depth.
module bulm_addr_gen #(
    parameter int ADDR_WIDTH = bulm_pkg::ADDR_WIDTH_DEF,
    parameter int BANK_DEPTH = bulm_pkg::BANK_DEPTH_DEF,
    localparam int RW        = $clog2(BANK_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bulm_req_if.sink                        req,
    input  logic                            take,
    output logic                            valid,
    output bulm_pkg::acc_ctrl_t             ctrl,
    output logic [bulm_pkg::DATA_WIDTH-1:0] wdata,
    output logic [RW-1:0]                   row_lo,
    output logic [RW-1:0]                   row_hi
);

    localparam int XW = ADDR_WIDTH - 2;
    localparam int SH = XW + RW;
    localparam int MW = XW + 2;
    localparam int PW = XW + MW;
    localparam int DW = XW + RW + 1;
    // floor(x * RECIP / 2^SH) equals floor(x / BANK_DEPTH) for every x below 2^XW
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(BANK_DEPTH) - 64'd1) / longint'(BANK_DEPTH);
    localparam logic [MW-1:0] RECIP_C  = MW'(RECIP);
    localparam logic [DW-1:0] DEPTH_C  = DW'(BANK_DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(BANK_DEPTH - 1);

    logic                            op_ok;
    bulm_pkg::acc_ctrl_t             ctrl_dec;
    logic [XW-1:0]                   row_in;
    logic [PW-1:0]                   prod;
    logic                            ready2;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    bulm_pkg::acc_ctrl_t             s1_ctrl_reg;
    logic [bulm_pkg::DATA_WIDTH-1:0] s1_wdata_reg;
    logic [XW-1:0]                   s1_row_reg;
    logic [PW-1:0]                   s1_prod_reg;

    logic [XW-1:0]                   quot;
    logic [DW-1:0]                   qd;
    logic [XW-1:0]                   rem;

    logic                            s2_valid_reg;
    logic                            s2_valid_next;
    bulm_pkg::acc_ctrl_t             s2_ctrl_reg;
    logic [bulm_pkg::DATA_WIDTH-1:0] s2_wdata_reg;
    logic [RW-1:0]                   s2_row_reg;
    logic                            s2_top_reg;

    always_comb
    begin
        op_ok          = 1'b1;
        ctrl_dec.store = 1'b0;
        ctrl_dec.size  = bulm_pkg::SIZE_BYTE;
        ctrl_dec.lane  = req.addr[1:0];
        unique case (req.op)
            bulm_pkg::OP_LOAD_BYTE:  ctrl_dec.size = bulm_pkg::SIZE_BYTE;
            bulm_pkg::OP_LOAD_HALF:  ctrl_dec.size = bulm_pkg::SIZE_HALF;
            bulm_pkg::OP_LOAD_WORD:  ctrl_dec.size = bulm_pkg::SIZE_WORD;
            bulm_pkg::OP_STORE_BYTE:
            begin
                ctrl_dec.store = 1'b1;
                ctrl_dec.size  = bulm_pkg::SIZE_BYTE;
            end
            bulm_pkg::OP_STORE_HALF:
            begin
                ctrl_dec.store = 1'b1;
                ctrl_dec.size  = bulm_pkg::SIZE_HALF;
            end
            bulm_pkg::OP_STORE_WORD:
            begin
                ctrl_dec.store = 1'b1;
                ctrl_dec.size  = bulm_pkg::SIZE_WORD;
            end
            default:                 op_ok = 1'b0;
        endcase
    end

    assign row_in = req.addr[ADDR_WIDTH-1:2];
    assign prod   = PW'(row_in) * PW'(RECIP_C);

    assign ready2    = !s2_valid_reg || take;
    assign req.ready = !s1_valid_reg || ready2;

    // Accept and drop undefined op codes
    assign s1_valid_next = req.ready ? (req.valid && op_ok) : s1_valid_reg;
    assign s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;

    assign quot = XW'(s1_prod_reg >> SH);
    assign qd   = DW'(quot) * DEPTH_C;
    assign rem  = s1_row_reg - XW'(qd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready)
        begin
            s1_ctrl_reg  <= ctrl_dec;
            s1_wdata_reg <= req.wdata;
            s1_row_reg   <= row_in;
            s1_prod_reg  <= prod;
        end
        if (ready2)
        begin
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_wdata_reg <= s1_wdata_reg;
            s2_row_reg   <= RW'(rem);
            s2_top_reg   <= &s1_row_reg;
        end
    end

    assign valid  = s2_valid_reg;
    assign ctrl   = s2_ctrl_reg;
    assign wdata  = s2_wdata_reg;
    assign row_lo = s2_row_reg;
    // The next row wraps to zero at the top of the address space or the bank
    assign row_hi = (s2_top_reg || s2_row_reg == LAST_ROW) ? '0 : s2_row_reg + 1'b1;

endmodule

[rtl/bulm_bank.sv]
// One byte-wide bank with a registered synchronous read port.
module bulm_bank #(
    parameter int BANK_DEPTH = bulm_pkg::BANK_DEPTH_DEF,
    localparam int RW        = $clog2(BANK_DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [RW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        // Hold the last read while the result waits downstream
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sim/bulm_checker.sv]
// Checker for the banked memory: shadow banks, expected load data, response compare.
`timescale 1ns / 1ps

module bulm_checker
    import bulm_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bulm_req_if  req,
    bulm_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    logic [7:0]            shadow_bank [NUM_BANKS][BANK_DEPTH];
    logic [DATA_WIDTH-1:0] load_data_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic int unsigned access_bytes(input op_t op);
        case (op)
            OP_LOAD_BYTE, OP_STORE_BYTE: return 1;
            OP_LOAD_HALF, OP_STORE_HALF: return 2;
            OP_LOAD_WORD, OP_STORE_WORD: return 4;
            default:                     return 0;
        endcase
    endfunction

    // Update the shadow banks for one transfer; return 1 when a load result is due.
    function automatic bit apply_access(input op_t op,
                                        input logic [ADDR_WIDTH-1:0] addr,
                                        input logic [DATA_WIDTH-1:0] wdata,
                                        output logic [DATA_WIDTH-1:0] load_data);
        int unsigned           nbytes;
        int unsigned           row;
        bit                    is_load;
        logic [ADDR_WIDTH-1:0] byte_addr;
        nbytes    = access_bytes(op);
        is_load   = (op == OP_LOAD_BYTE) || (op == OP_LOAD_HALF) || (op == OP_LOAD_WORD);
        load_data = '0;
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            // Bytes past the top address wrap to address 0
            byte_addr = addr + ADDR_WIDTH'(i);
            row       = int'(byte_addr >> 2) % BANK_DEPTH;
            if (is_load)
            begin
                load_data = {load_data[DATA_WIDTH-9:0], shadow_bank[byte_addr[1:0]][row]};
            end
            else
            begin
                shadow_bank[byte_addr[1:0]][row] = wdata[8*(nbytes-1-i) +: 8];
            end
        end
        return is_load && (nbytes != 0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [DATA_WIDTH-1:0] load_data;
        if (!rst_n)
        begin
            load_data_q.delete();
            pending <= 0;
        end
        else
        begin
            // Take the request first so a same-edge response still finds its entry
            if (req.valid && req.ready)
            begin
                if (apply_access(op_t'(req.op), req.addr, req.wdata, load_data))
                begin
                    load_data_q.push_back(load_data);
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (load_data_q.size() == 0)
                begin
                    errors = errors + 1;
                    $error("rdata: no load outstanding, actual %08h", rsp.rdata);
                end
                else
                begin
                    load_data = load_data_q.pop_front();
                    if (rsp.rdata !== load_data)
                    begin
                        errors = errors + 1;
                        $error("rdata mismatch: expected %08h, actual %08h",
                               load_data, rsp.rdata);
                    end
                end
            end
            pending <= load_data_q.size();
        end
    end

endmodule

[sim/tb_banked_unaligned_load_store_memory.sv]
// Testbench top: clock, reset, request stimulus and verdict for the banked memory.
`timescale 1ns / 1ps

module tb_banked_unaligned_load_store_memory;
    import bulm_pkg::*;

    localparam int ADDR_WIDTH      = ADDR_WIDTH_DEF;
    localparam int BANK_DEPTH      = BANK_DEPTH_DEF;
    localparam int MEM_BYTES       = 1 << ADDR_WIDTH;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [OP_WIDTH-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_UNDEF_HI = 3'd7;

    typedef enum int { PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH } phase_t;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    phase_t phase = PH_FREE;
    bit     hold_rsp = 1'b0;
    int     cycles = 0;
    int     errors;
    int     pending;
    bit     written [MEM_BYTES];

    const op_t load_ops  [3] = '{OP_LOAD_BYTE, OP_LOAD_HALF, OP_LOAD_WORD};
    const op_t store_ops [3] = '{OP_STORE_BYTE, OP_STORE_HALF, OP_STORE_WORD};

    bulm_req_if #(.ADDR_WIDTH(ADDR_WIDTH)) req_if ();
    bulm_rsp_if                            rsp_if ();

    banked_unaligned_load_store_memory #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .BANK_DEPTH (BANK_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    bulm_checker #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .BANK_DEPTH (BANK_DEPTH)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit src_idle();
        case (phase)
            PH_SRC_IDLE: return $urandom_range(0, 99) < 65;
            PH_BOTH:     return $urandom_range(0, 99) < 25;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stall();
        case (phase)
            PH_SNK_STALL: return $urandom_range(0, 99) < 65;
            PH_BOTH:      return $urandom_range(0, 99) < 25;
            default:      return 1'b0;
        endcase
    endfunction

    // Response side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_rsp  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= !sink_stall();
            end
        end
    end

    function automatic bit span_written(input logic [ADDR_WIDTH-1:0] addr,
                                        input int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            if (!written[ADDR_WIDTH'(addr + i)])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic issue(input logic [OP_WIDTH-1:0] op, input logic [ADDR_WIDTH-1:0] addr,
                         input logic [DATA_WIDTH-1:0] wdata);
        int unsigned nbytes;
        nbytes = 0;
        case (op)
            OP_STORE_BYTE: nbytes = 1;
            OP_STORE_HALF: nbytes = 2;
            OP_STORE_WORD: nbytes = 4;
            default:       nbytes = 0;
        endcase
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            written[ADDR_WIDTH'(addr + i)] = 1'b1;
        end
        while (src_idle())
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.addr  <= addr;
        req_if.wdata <= wdata;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // Mostly loads of written bytes and stores; a few undefined codes as noise
    task automatic random_access(output bit counted);
        int unsigned           pick;
        int unsigned           size;
        int unsigned           tries;
        bit                    found;
        logic [ADDR_WIDTH-1:0] addr;
        pick    = $urandom_range(0, 99);
        size    = $urandom_range(0, 2);
        addr    = ADDR_WIDTH'($urandom);
        counted = 1'b1;
        if (pick < 4)
        begin
            counted = 1'b0;
            issue($urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO, addr, $urandom);
        end
        else if (pick < 52)
        begin
            found = span_written(addr, 1 << size);
            tries = 0;
            while (!found && tries < 16)
            begin
                addr  = ADDR_WIDTH'($urandom);
                found = span_written(addr, 1 << size);
                tries++;
            end
            if (found)
            begin
                issue(load_ops[size], addr, $urandom);
            end
            else
            begin
                issue(store_ops[size], addr, $urandom);
            end
        end
        else
        begin
            issue(store_ops[size], addr, $urandom);
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int count;
        bit counted;
        req_if.valid = 1'b0;
        req_if.op    = OP_LOAD_BYTE;
        req_if.addr  = '0;
        req_if.wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Aligned, unaligned, row-crossing and top-of-space wrapping accesses
        issue(OP_STORE_WORD, 8'd0,   32'h0123_4567);
        issue(OP_STORE_WORD, 8'd4,   32'h89ab_cdef);
        issue(OP_LOAD_WORD,  8'd0,   32'h0);
        issue(OP_LOAD_WORD,  8'd1,   32'hffff_ffff);
        issue(OP_LOAD_HALF,  8'd3,   32'h0);
        issue(OP_LOAD_BYTE,  8'd7,   32'h0);
        issue(OP_STORE_WORD, 8'd254, 32'hffff_ffff);
        issue(OP_STORE_HALF, 8'd252, 32'hdead_beef);
        issue(OP_LOAD_WORD,  8'd252, 32'h0);
        issue(OP_LOAD_WORD,  8'd255, 32'h0);
        issue(OP_STORE_BYTE, 8'd255, 32'h0000_0000);
        issue(OP_LOAD_HALF,  8'd255, 32'h0);
        issue(OP_STORE_HALF, 8'd1,   32'hffff_0000);
        issue(OP_LOAD_BYTE,  8'd255, 32'h0);
        issue(OP_LOAD_WORD,  8'd0,   32'h0);
        issue(OP_STORE_WORD, 8'd3,   32'ha5c3_5a3c);
        issue(OP_LOAD_WORD,  8'd3,   32'h0);
        issue(OP_LOAD_HALF,  8'd2,   32'h0);
        issue(OP_UNDEF_LO,   8'd255, 32'hffff_ffff);
        issue(OP_UNDEF_HI,   8'd0,   32'h0);
        issue(OP_LOAD_BYTE,  8'd0,   32'h0);
        issue(OP_STORE_BYTE, 8'd128, 32'hffff_ff80);
        issue(OP_LOAD_WORD,  8'd253, 32'h0);
        drain();

        for (int p = PH_FREE; p <= PH_BOTH; p++)
        begin
            phase = phase_t'(p);
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                // Hold the response side off so the block fills and stalls requests
                if (phase == PH_FREE && count == 100)
                begin
                    hold_rsp = 1'b1;
                end
                random_access(counted);
                if (counted)
                begin
                    count++;
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
